FILE: rtl/core/glp_pkg.sv
package glp_pkg;

  // Default geometry of the two stores
  localparam int LOOP_ADDR_BITS   = 18;
  localparam int WINDOW_ADDR_BITS = 11;

  // Fixed field widths
  localparam int SAMPLE_W = 24;
  localparam int POS_W    = 16;
  localparam int COEF_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int GLEN_W   = 12;
  localparam int GCNT_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] Q15_ONE   = 16'd32768;
  localparam logic [GLEN_W-1:0] MAX_GRAIN = 12'd2048;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_LENGTH  = 2'd2;

  // Input opcodes
  localparam logic OP_AUDIO       = 1'b0;
  localparam logic OP_WINDOW_LOAD = 1'b1;

  // Stage enables from the sequencer to the arithmetic pipe
  typedef struct packed {
    logic mul_en;
    logic mix_en;
  } glp_ctrl_t;

endpackage

FILE: rtl/core/glp_ram.sv
module glp_ram #(
  parameter int WIDTH     = 24,
  parameter int ADDR_BITS = 18
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/glp_mix.sv
module glp_mix (
  input  logic                                 clk,
  input  glp_pkg::glp_ctrl_t                   ctrl,
  input  logic signed [glp_pkg::SAMPLE_W-1:0]  loop_sample,
  input  logic [glp_pkg::COEF_W-1:0]           win_word,
  input  logic signed [glp_pkg::SAMPLE_W-1:0]  dry,
  input  logic [glp_pkg::GAIN_W-1:0]           gain,
  output logic signed [glp_pkg::SAMPLE_W-1:0]  result
);

  localparam int WPROD_W = glp_pkg::SAMPLE_W + glp_pkg::COEF_W + 1;
  localparam int WET_W   = glp_pkg::SAMPLE_W + 1;
  localparam int G_W     = glp_pkg::GAIN_W + 1;
  localparam int PW_W    = WET_W + G_W;
  localparam int SUM_W   = PW_W + 1;
  localparam int SH_W    = SUM_W - 15;
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(8388607);
  localparam logic signed [SH_W-1:0] SAT_MIN = -SH_W'(8388608);

  logic signed [WPROD_W-1:0] wet_prod;
  logic signed [PW_W-1:0]    p_wet;
  logic signed [PW_W-1:0]    p_dry;
  logic signed [WET_W-1:0]   wet;
  logic signed [G_W-1:0]     g_wet;
  logic signed [G_W-1:0]     g_dry;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SH_W-1:0]    scaled;

  // Arithmetic shift is floor division by 2^15
  assign wet   = WET_W'(wet_prod >>> 15);
  assign g_wet = signed'({1'b0, gain});
  assign g_dry = signed'({1'b0, glp_pkg::Q15_ONE - gain});

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      wet_prod <= WPROD_W'(loop_sample) * signed'(WPROD_W'({1'b0, win_word}));
    end
    if (ctrl.mix_en) begin
      p_wet <= PW_W'(wet) * PW_W'(g_wet);
      p_dry <= PW_W'(dry) * PW_W'(g_dry);
    end
  end

  assign sum    = SUM_W'(p_wet) + SUM_W'(p_dry);
  assign scaled = SH_W'(sum >>> 15);

  always_comb begin
    if (scaled > SAT_MAX) begin
      result = glp_pkg::SAMPLE_W'(SAT_MAX);
    end else if (scaled < SAT_MIN) begin
      result = glp_pkg::SAMPLE_W'(SAT_MIN);
    end else begin
      result = glp_pkg::SAMPLE_W'(scaled);
    end
  end

endmodule

FILE: rtl/core/granular_loop_player.sv
// Channel | Handshake                 | Payload
// --------+---------------------------+------------------------------------------------
// in      | in_valid / in_stall       | opcode, dry_sample, grain_position,
//         |                           | window_address, window_value
// out     | out_valid / out_stall     | mixed_sample
// cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// An audio transaction passes through S_MUL, S_MIX and S_SUM to the output register. The
// acceptance edge launches the loop and window memory reads. S_MUL multiplies by the
// window word, S_MIX forms the two gain products, and S_SUM sums and saturates. in_stall
// stays high through those states, so no new audio transaction is accepted until the
// last one leaves S_SUM. A window load is written at its acceptance and raises no stall.
// After reset, a clearing pass zeroes every entry of the loop memory with in_stall high;
// configuration writes are taken throughout.
// A stalled output holds its result; the next transaction is still accepted and waits
// in the last stage until the output register frees.
module granular_loop_player #(
  parameter int LOOP_ADDR_BITS   = glp_pkg::LOOP_ADDR_BITS,
  parameter int WINDOW_ADDR_BITS = glp_pkg::WINDOW_ADDR_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input transactions
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   opcode,
  input  logic signed [glp_pkg::SAMPLE_W-1:0]    dry_sample,
  input  logic signed [glp_pkg::POS_W-1:0]       grain_position,
  input  logic [glp_pkg::GCNT_W-1:0]             window_address,
  input  logic [glp_pkg::COEF_W-1:0]             window_value,
  // results
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [glp_pkg::SAMPLE_W-1:0]    mixed_sample,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [glp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [glp_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int LA = LOOP_ADDR_BITS;
  localparam int WA = WINDOW_ADDR_BITS;
  localparam int GC = glp_pkg::GCNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_MIX,
    S_SUM
  } state_t;

  state_t state;

  // configuration
  logic                        record_enable;
  logic [glp_pkg::GAIN_W-1:0]  mix_gain;
  logic [glp_pkg::GLEN_W-1:0]  grain_length;

  // loop state
  logic [LA-1:0] write_index;
  logic [LA-1:0] clr_addr;
  logic [GC-1:0] grain_counter;
  logic [GC-1:0] grain_counter_next;

  // per transaction
  logic signed [glp_pkg::SAMPLE_W-1:0] dry;
  logic                                fwd;

  logic in_accept;
  logic audio_accept;
  logic load_accept;
  logic cfg_write;
  logic out_free;

  logic [LA+15:0] pos_scaled;
  logic [LA+11:0] ridx_sum;
  logic [LA-1:0]  ridx;
  logic [WA+GC-1:0] win_rd_ext;
  logic [WA+GC-1:0] win_wr_ext;

  logic                                loop_we;
  logic [LA-1:0]                       loop_waddr;
  logic [glp_pkg::SAMPLE_W-1:0]        loop_wdata;
  logic [glp_pkg::SAMPLE_W-1:0]        loop_rdata;
  logic [glp_pkg::COEF_W-1:0]          win_rdata;
  logic signed [glp_pkg::SAMPLE_W-1:0] loop_sample;
  logic [glp_pkg::GAIN_W-1:0]          gain;
  logic [glp_pkg::GLEN_W-1:0]          glen;
  logic [glp_pkg::GLEN_W-1:0]          gc_inc;
  logic signed [glp_pkg::SAMPLE_W-1:0] mix_result;

  glp_pkg::glp_ctrl_t ctrl;

  assign in_stall     = (state != S_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign audio_accept = in_accept && (opcode == glp_pkg::OP_AUDIO);
  assign load_accept  = in_accept && (opcode == glp_pkg::OP_WINDOW_LOAD);
  assign cfg_ready    = 1'b1;
  assign cfg_write    = cfg_valid && cfg_ready;
  assign out_free     = !out_valid || !out_stall;

  // Map signed Q15 position to the top LA bits of (pos + 1.0) * loop size
  assign pos_scaled = {~grain_position[glp_pkg::POS_W-1],
                       grain_position[glp_pkg::POS_W-2:0], {LA{1'b0}}};
  assign ridx_sum   = {12'b0, pos_scaled[LA+15:16]} + {{(LA+1){1'b0}}, grain_counter};
  assign ridx       = ridx_sum[LA-1:0];

  assign win_rd_ext = {{WA{1'b0}}, grain_counter};
  assign win_wr_ext = {{WA{1'b0}}, window_address};

  // Clearing pass owns the write port until it finishes
  always_comb begin
    if (state == S_CLEAR) begin
      loop_we    = 1'b1;
      loop_waddr = clr_addr;
      loop_wdata = '0;
    end else begin
      loop_we    = audio_accept && record_enable;
      loop_waddr = write_index;
      loop_wdata = dry_sample;
    end
  end

  glp_ram #(
    .WIDTH     (glp_pkg::SAMPLE_W),
    .ADDR_BITS (LA)
  ) u_loop_ram (
    .clk   (clk),
    .we    (loop_we),
    .waddr (loop_waddr),
    .wdata (loop_wdata),
    .raddr (ridx),
    .rdata (loop_rdata)
  );

  glp_ram #(
    .WIDTH     (glp_pkg::COEF_W),
    .ADDR_BITS (WA)
  ) u_window_ram (
    .clk   (clk),
    .we    (load_accept),
    .waddr (win_wr_ext[WA-1:0]),
    .wdata (window_value),
    .raddr (win_rd_ext[WA-1:0]),
    .rdata (win_rdata)
  );

  // Read after write: a read of the entry written this transaction sees the new sample
  assign loop_sample = fwd ? dry : signed'(loop_rdata);

  assign gain = (mix_gain > glp_pkg::Q15_ONE) ? glp_pkg::Q15_ONE : mix_gain;
  assign glen = (grain_length > glp_pkg::MAX_GRAIN) ? glp_pkg::MAX_GRAIN : grain_length;

  // Wrap once the counter reaches the grain length; lengths of 0 or 1 pin it at 0
  assign gc_inc = {1'b0, grain_counter} + 12'd1;
  assign grain_counter_next = (gc_inc >= glen) ? '0 : gc_inc[GC-1:0];

  assign ctrl = '{mul_en: (state == S_MUL), mix_en: (state == S_MIX)};

  glp_mix u_mix (
    .clk         (clk),
    .ctrl        (ctrl),
    .loop_sample (loop_sample),
    .win_word    (win_rdata),
    .dry         (dry),
    .gain        (gain),
    .result      (mix_result)
  );

  // Sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (audio_accept) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_MIX;
        end
        S_MIX: begin
          state <= S_SUM;
        end
        S_SUM: begin
          // hold here while the previous result is still stalled
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
      // Load the output register as the last stage retires; drop valid once taken
      if ((state == S_SUM) && out_free) begin
        out_valid    <= 1'b1;
        mixed_sample <= mix_result;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Clear address sweeps the loop memory once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Capture the dry sample and the forwarding decision at acceptance
  always_ff @(posedge clk) begin
    if (audio_accept) begin
      dry <= dry_sample;
      fwd <= record_enable && (ridx == write_index);
    end
  end

  // Configuration registers and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      record_enable <= 1'b0;
      mix_gain      <= 16'd16384;
      grain_length  <= 12'd480;
      write_index   <= '0;
      grain_counter <= '0;
    end else begin
      if (audio_accept) begin
        write_index <= write_index + 1'b1;
      end
      // A grain length write restarts the grain
      if (cfg_write && (cfg_index == glp_pkg::CFG_GRAIN_LENGTH)) begin
        grain_counter <= '0;
      end else if (audio_accept) begin
        grain_counter <= grain_counter_next;
      end
      if (cfg_write) begin
        case (cfg_index)
          glp_pkg::CFG_RECORD_ENABLE: record_enable <= cfg_data[0];
          glp_pkg::CFG_MIX_GAIN:      mix_gain      <= cfg_data;
          glp_pkg::CFG_GRAIN_LENGTH:  grain_length  <= cfg_data[glp_pkg::GLEN_W-1:0];
          default: begin
            // drop writes to unmapped indexes
          end
        endcase
      end
    end
  end

endmodule

FILE: dv/tb_granular_loop_player.sv
`timescale 1ns / 100ps

module tb_granular_loop_player;

  // Geometry of the block under test, taken from the package defaults
  localparam int     LOOP_DEPTH   = 1 << glp_pkg::LOOP_ADDR_BITS;
  localparam longint LOOP_MASK    = LOOP_DEPTH - 1;
  localparam int     WIN_DEPTH    = 1 << glp_pkg::WINDOW_ADDR_BITS;
  localparam int     POS_SHIFT    = glp_pkg::LOOP_ADDR_BITS - glp_pkg::POS_W;
  localparam longint SAMPLE_MAX   = 64'sd8388607;
  localparam longint SAMPLE_MIN   = -64'sd8388608;

  // Run control. The clearing pass alone sweeps all LOOP_DEPTH entries; the rest of the
  // run stays well inside CYCLE_LIMIT even with every gap and stall at its longest.
  localparam int CYCLE_LIMIT  = 1200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET  = 1650;
  localparam int MAX_REPORTS  = 20;

  // One input transaction as queued for the driver
  typedef struct packed {
    logic                               op;
    logic [glp_pkg::SAMPLE_W-1:0]       dry;
    logic [glp_pkg::POS_W-1:0]          pos;
    logic [glp_pkg::GCNT_W-1:0]         waddr;
    logic [glp_pkg::COEF_W-1:0]         wval;
  } player_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 in_valid       = 1'b0;
  logic                                 in_stall;
  logic                                 opcode         = glp_pkg::OP_AUDIO;
  logic signed [glp_pkg::SAMPLE_W-1:0]  dry_sample     = '0;
  logic signed [glp_pkg::POS_W-1:0]     grain_position = '0;
  logic [glp_pkg::GCNT_W-1:0]           window_address = '0;
  logic [glp_pkg::COEF_W-1:0]           window_value   = '0;
  logic                                 out_valid;
  logic                                 out_stall      = 1'b0;
  logic signed [glp_pkg::SAMPLE_W-1:0]  mixed_sample;
  logic                                 cfg_valid      = 1'b0;
  logic                                 cfg_ready;
  logic [glp_pkg::CFG_IDX_W-1:0]        cfg_index      = glp_pkg::CFG_RECORD_ENABLE;
  logic [glp_pkg::CFG_DATA_W-1:0]       cfg_data       = '0;

  granular_loop_player i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .dry_sample     (dry_sample),
    .grain_position (grain_position),
    .window_address (window_address),
    .window_value   (window_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mixed_sample   (mixed_sample),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Player state as the predictor sees it. Two-state arrays start at zero, which
  // matches the loop memory after the clearing pass.
  // ---------------------------------------------------------------------------
  bit signed [glp_pkg::SAMPLE_W-1:0]      loop_store   [LOOP_DEPTH];
  bit [glp_pkg::COEF_W-1:0]               window_store [WIN_DEPTH];
  bit [glp_pkg::LOOP_ADDR_BITS-1:0]       play_wr_idx    = '0;
  bit [glp_pkg::GCNT_W-1:0]               play_grain_cnt = '0;
  bit                                     rec_on         = 1'b0;
  bit [glp_pkg::GAIN_W-1:0]               gain_reg       = 16'd16384;
  bit [glp_pkg::GLEN_W-1:0]               glen_reg       = 12'd480;

  logic signed [glp_pkg::SAMPLE_W-1:0]    expected_mix [$];
  logic signed [glp_pkg::SAMPLE_W-1:0]    mix_want;

  // Stimulus-side shadow: tracks which window entry the next audio transaction
  // reads, so that no entry is read before it has been loaded.
  bit                                     gen_written [WIN_DEPTH];
  int unsigned                            gen_cnt = 0;
  int unsigned                            gen_len = 480;
  int unsigned                            gen_wr  = 0;

  player_item_t                           pending_items [$];

  int items_queued   = 0;
  int items_taken    = 0;
  int audio_count    = 0;
  int rec_count      = 0;
  int load_count     = 0;
  int sat_count      = 0;
  int reg_writes     = 0;
  int err_count      = 0;
  int cycle_count    = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  bit in_burst       = 1'b0;
  bit out_burst      = 1'b0;

  task automatic report_mismatch(input string what,
                                 input logic [glp_pkg::SAMPLE_W-1:0] got,
                                 input logic [glp_pkg::SAMPLE_W-1:0] want);
    if (err_count < MAX_REPORTS)
      $display("ERROR @%0t: %s: mixed_sample got %0d, want %0d",
               $time, what, $signed(got), $signed(want));
    err_count++;
  endtask

  // Apply a register write to the predictor's copy of the configuration
  task automatic apply_register_write(input logic [glp_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [glp_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      glp_pkg::CFG_RECORD_ENABLE: rec_on = data[0];
      glp_pkg::CFG_MIX_GAIN:      gain_reg = data;
      glp_pkg::CFG_GRAIN_LENGTH: begin
        glen_reg       = data[glp_pkg::GLEN_W-1:0];
        play_grain_cnt = '0;
      end
      default: ;
    endcase
  endtask

  // Advance the player by one accepted transaction and queue the mix it produces
  task automatic predict_player_step(input logic op,
                                     input logic signed [glp_pkg::SAMPLE_W-1:0] dry,
                                     input logic signed [glp_pkg::POS_W-1:0] pos,
                                     input logic [glp_pkg::GCNT_W-1:0] waddr,
                                     input logic [glp_pkg::COEF_W-1:0] wval);
    longint      base;
    longint      loop_val;
    longint      coef;
    longint      wet;
    longint      gain;
    longint      mix;
    int unsigned ridx;
    int unsigned eff_len;
    int unsigned next_cnt;
    items_taken++;
    if (op == glp_pkg::OP_WINDOW_LOAD) begin
      window_store[waddr % WIN_DEPTH] = wval;
      load_count++;
      return;
    end
    audio_count++;
    // Write first: a read at the write index sees the new sample
    if (rec_on) begin
      loop_store[play_wr_idx] = dry;
      rec_count++;
    end
    base     = ((longint'(pos) + 32768) << glp_pkg::LOOP_ADDR_BITS) >> 16;
    ridx     = (base + play_grain_cnt) & LOOP_MASK;
    loop_val = loop_store[ridx];
    coef     = window_store[play_grain_cnt % WIN_DEPTH];
    wet      = (loop_val * coef) >>> 15;
    gain     = (gain_reg > glp_pkg::Q15_ONE) ? 64'sd32768 : longint'(gain_reg);
    mix      = (wet * gain + longint'(dry) * (64'sd32768 - gain)) >>> 15;
    if (mix > SAMPLE_MAX) begin
      mix = SAMPLE_MAX;
      sat_count++;
    end else if (mix < SAMPLE_MIN) begin
      mix = SAMPLE_MIN;
      sat_count++;
    end
    expected_mix.push_back(mix[glp_pkg::SAMPLE_W-1:0]);
    play_wr_idx = play_wr_idx + 1'b1;
    eff_len  = (glen_reg > glp_pkg::MAX_GRAIN) ? glp_pkg::MAX_GRAIN : glen_reg;
    next_cnt = play_grain_cnt + 1;
    if (next_cnt >= eff_len)
      next_cnt = 0;
    play_grain_cnt = next_cnt;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned rand_coef();
    // Mostly a proper Q15 window word, now and then one above unity
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(32769, 65535);
    return $urandom_range(0, 32768);
  endfunction

  function automatic logic [glp_pkg::SAMPLE_W-1:0] rand_dry();
    case ($urandom_range(0, 19))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // Aim as many reads at recently recorded samples as anywhere, and the rest at the ends
  function automatic logic [glp_pkg::POS_W-1:0] rand_position();
    int unsigned sel;
    longint      target;
    sel = $urandom_range(0, 9);
    if (sel < 4)
      return $urandom;
    if (sel < 8) begin
      target = (longint'(gen_wr) - longint'($urandom_range(0, 64)) - longint'(gen_cnt))
               & LOOP_MASK;
      return (target >> POS_SHIFT) - 32768;
    end
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic queue_load(input int unsigned addr, input int unsigned val);
    player_item_t it;
    it.op    = glp_pkg::OP_WINDOW_LOAD;
    it.dry   = $urandom;
    it.pos   = $urandom;
    it.waddr = addr;
    it.wval  = val;
    pending_items.push_back(it);
    gen_written[addr % WIN_DEPTH] = 1'b1;
    items_queued++;
  endtask

  task automatic queue_audio(input logic [glp_pkg::SAMPLE_W-1:0] dry,
                             input logic [glp_pkg::POS_W-1:0] pos);
    player_item_t it;
    int unsigned  eff_len;
    // Load the window entry this grain step reads if nothing has been put there
    if (!gen_written[gen_cnt % WIN_DEPTH])
      queue_load(gen_cnt % WIN_DEPTH, rand_coef());
    it.op    = glp_pkg::OP_AUDIO;
    it.dry   = dry;
    it.pos   = pos;
    it.waddr = $urandom;
    it.wval  = $urandom;
    pending_items.push_back(it);
    items_queued++;
    gen_wr  = (gen_wr + 1) & LOOP_MASK;
    eff_len = (gen_len > glp_pkg::MAX_GRAIN) ? glp_pkg::MAX_GRAIN : gen_len;
    gen_cnt = gen_cnt + 1;
    if (gen_cnt >= eff_len)
      gen_cnt = 0;
  endtask

  // Hold until every queued transaction is taken and every result has come back
  task automatic wait_drained();
    while (items_taken != items_queued || expected_mix.size() != 0)
      @(posedge clk);
    // Window loads produce no result; give the pipe time to retire them
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [glp_pkg::CFG_IDX_W-1:0] idx,
                              input logic [glp_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == glp_pkg::CFG_GRAIN_LENGTH) begin
      gen_len = data[glp_pkg::GLEN_W-1:0];
      gen_cnt = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transaction from the pending queue at a time, with a random gap
  // after each, or none during a burst. Hold valid and payload while the block stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    player_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        opcode         <= nxt.op;
        dry_sample     <= nxt.dry;
        grain_position <= nxt.pos;
        window_address <= nxt.waddr;
        window_value   <= nxt.wval;
        in_valid       <= 1'b1;
        // Switch between back-to-back bursts and gappy traffic now and then
        if ($urandom_range(0, 63) == 0)
          in_burst = !in_burst;
        gap_left = in_burst ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict on every accepted input, check every
  // accepted result, and stall the output for a random count after each result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        apply_register_write(cfg_index, cfg_data);
      // Check before predicting so a result never matches a same-edge input
      if (out_valid && !out_stall) begin
        if (expected_mix.size() == 0) begin
          report_mismatch("result with no transaction pending", mixed_sample, '0);
        end else begin
          mix_want = expected_mix.pop_front();
          if (mixed_sample !== mix_want)
            report_mismatch("wrong mix", mixed_sample, mix_want);
        end
        if ($urandom_range(0, 63) == 0)
          out_burst = !out_burst;
        stall_left = out_burst ? 0 : $urandom_range(0, 5);
      end
      if (in_valid && !in_stall)
        predict_player_step(opcode, dry_sample, grain_position, window_address,
                            window_value);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d transactions taken",
               cycle_count, items_taken, items_queued);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed corners first, then random register settings with random
  // traffic until the item budget is spent.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n_items;
    int unsigned glen_val;
    logic [glp_pkg::GAIN_W-1:0] gain_val;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Record with full wet gain and a four-step grain
    set_register(glp_pkg::CFG_RECORD_ENABLE, 16'd1);
    set_register(glp_pkg::CFG_MIX_GAIN, 16'd32768);
    set_register(glp_pkg::CFG_GRAIN_LENGTH, 16'd4);
    queue_load(0, 65535);
    queue_load(1, 32768);
    queue_load(2, 65535);
    queue_load(3, 0);
    queue_load(WIN_DEPTH - 1, 32768);
    // Read back the sample just written, window above unity: positive clip
    queue_audio(24'h7FFFFF, 16'h8000);
    // Full-scale negative at unity window
    queue_audio(24'h800000, 16'h8000);
    // Full-scale negative above unity window: negative clip
    queue_audio(24'h800000, 16'h8000);
    queue_audio(24'h000001, 16'h7FFF);
    queue_audio(24'hFFFFFF, 16'h0000);

    // Dry only, grain counter held at zero, playback only
    set_register(glp_pkg::CFG_MIX_GAIN, 16'd0);
    set_register(glp_pkg::CFG_GRAIN_LENGTH, 16'd0);
    set_register(glp_pkg::CFG_RECORD_ENABLE, 16'hFFFE);
    queue_audio(24'h800000, 16'hFFFF);
    queue_audio(24'h7FFFFF, 16'h7FFF);

    // Gain past unity acts as full wet; grain length of one also holds at zero
    set_register(glp_pkg::CFG_MIX_GAIN, 16'hFFFF);
    set_register(glp_pkg::CFG_GRAIN_LENGTH, 16'd1);
    queue_audio(24'h123456, 16'h8000);
    queue_audio(24'hABCDEF, 16'h8000);

    // Grain length past the maximum, with junk in the upper data bits
    set_register(glp_pkg::CFG_GRAIN_LENGTH, 16'hFFFF);
    queue_audio(24'h7FFFFF, 16'h8000);
    queue_audio(24'h000000, 16'h4000);
    queue_audio(24'h800000, 16'hC000);

    set_register(glp_pkg::CFG_GRAIN_LENGTH, 16'd2048);
    queue_audio(24'h400000, 16'h8000);
    queue_audio(24'hC00000, 16'h7FFF);

    while (items_queued < ITEM_TARGET) begin
      // New setting: each register is rewritten about two times in three
      if ($urandom_range(0, 2) != 0)
        set_register(glp_pkg::CFG_RECORD_ENABLE,
                     ($urandom & 16'hFFFE) | ($urandom_range(0, 9) < 7));
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       gain_val = 16'd0;
          1:       gain_val = 16'd32768;
          2:       gain_val = 16'hFFFF;
          3:       gain_val = 16'd16384;
          4:       gain_val = $urandom_range(0, 32768);
          default: gain_val = $urandom;
        endcase
        set_register(glp_pkg::CFG_MIX_GAIN, gain_val);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 11))
          0:          glen_val = 0;
          1:          glen_val = 1;
          2:          glen_val = 2;
          3:          glen_val = 2048;
          4:          glen_val = 4095;
          5:          glen_val = $urandom_range(2049, 4095);
          6, 7, 8:    glen_val = $urandom_range(2, 16);
          9, 10:      glen_val = $urandom_range(2, 64);
          default:    glen_val = $urandom_range(2, 2048);
        endcase
        set_register(glp_pkg::CFG_GRAIN_LENGTH, (($urandom & 32'hF) << 12) | glen_val);
      end

      n_items = $urandom_range(60, 220);
      repeat (n_items) begin
        // Stop at the item budget
        if (items_queued < ITEM_TARGET) begin
          if ($urandom_range(0, 6) == 0)
            queue_load($urandom_range(0, WIN_DEPTH - 1), rand_coef());
          else
            queue_audio(rand_dry(), rand_position());
        end
      end
    end

    wait_drained();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d audio transactions (%0d recorded, %0d clipped) and %0d window loads",
             audio_count, rec_count, sat_count, load_count);
    $display("across %0d register writes; %0d mismatches", reg_writes, err_count);
    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
